/* rtl/prefixed_command_line_parser_unit_macros.svh */
// Assertion macros shared by the checker of the command line parser.
`ifndef PREFIXED_COMMAND_LINE_PARSER_UNIT_MACROS_SVH
`define PREFIXED_COMMAND_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCLP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCLP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pclp_pkg.sv */
// Package with types, constants and helper functions of the command line parser.
package pclp_pkg;

    localparam int PREFIX_CHARS        = 2;
    localparam int MAX_DIGITS_PLUS_ONE = 6;
    localparam int LINE_SLOTS          = 18;

    localparam int HELD_W  = $clog2(LINE_SLOTS);
    localparam int DCNT_W  = $clog2(MAX_DIGITS_PLUS_ONE);
    localparam int CMD_ROWS = 13;
    localparam int ROW_W   = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [15:0] PREFIX_RESET = 16'h2424;

    localparam logic [7:0] CHAR_NL    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_QUERY = 8'h3f;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    localparam logic [7:0] CMD_LETTERS [CMD_ROWS] = '{
        "h", "v", "r", "p", "d", "w", "s", "g", "l", "c", "n", "f", "q"
    };

    typedef enum logic [2:0] {
        OUT_COMMAND  = 3'd0,
        OUT_UNKNOWN  = 3'd1,
        OUT_PREFIX   = 3'd2,
        OUT_NONDIGIT = 3'd3,
        OUT_TOOLONG  = 3'd4,
        OUT_OVERFLOW = 3'd5
    } outcome_t;

    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_PREFIX   = 2'd1,
        FAULT_NONDIGIT = 2'd2,
        FAULT_TOOLONG  = 2'd3
    } fault_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_NEWLINE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic             is_digit;
        logic [3:0]       digit;
        logic             cmd_hit;
        logic [ROW_W-1:0] cmd_row;
    } item_t;

    // Returns {hit, row}; the lowest matching row wins.
    function automatic logic [ROW_W:0] cmd_lookup(input logic [7:0] b);
        logic             hit;
        logic [ROW_W-1:0] row;
        hit = 1'b0;
        row = '0;
        for (int r = CMD_ROWS - 1; r >= 0; r--) begin
            if ((b == CMD_LETTERS[r])
                || ((r != CMD_ROWS - 1) && (b == (CMD_LETTERS[r] - CASE_DIFF)))
                || ((r == 0) && (b == CHAR_QUERY))
                || ((r != 0) && (r != CMD_ROWS - 1) && (b == CHAR_NUL))) begin
                hit = 1'b1;
                row = ROW_W'(r);
            end
        end
        return {hit, row};
    endfunction

    // Expected prefix character at a position; position zero reads the high byte, later positions read the low byte.
    function automatic logic [7:0] prefix_char(input logic [15:0] pfx,
                                               input logic [HELD_W-1:0] pos);
        int sh;
        sh = PREFIX_CHARS - 1 - int'(pos);
        if (sh >= 2) begin
            return 8'h00;
        end else if (sh == 1) begin
            return pfx[15:8];
        end else begin
            return pfx[7:0];
        end
    endfunction

endpackage

/* rtl/pclp_front.sv */
// Front end: accepts received bytes, drops carriage returns and classifies each byte.
module pclp_front (
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] rx_byte
    input  logic                 q_full,
    output logic                 push,
    output pclp_pkg::item_t      push_item
);
    import pclp_pkg::*;

    logic [ROW_W:0] lookup;

    assign lookup   = cmd_lookup(s_tdata);
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && (s_tdata != CHAR_CR);

    always_comb begin
        push_item.kind     = (s_tdata == CHAR_NL) ? KIND_NEWLINE : KIND_DATA;
        push_item.data     = s_tdata;
        push_item.is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
        push_item.digit    = 4'(s_tdata - CHAR_ZERO);
        push_item.cmd_hit  = lookup[ROW_W];
        push_item.cmd_row  = lookup[ROW_W-1:0];
    end

endmodule

/* rtl/pclp_queue.sv */
// Short queue of classified bytes between the front end and the line engine.
module pclp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  pclp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output pclp_pkg::item_t q_item
);
    import pclp_pkg::*;

    item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* rtl/pclp_back.sv */
// Line engine: tracks the line state, builds results and holds them in the output register.
module pclp_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [15:0]                  cfg_wdata,
    input  logic                         q_valid,
    input  pclp_pkg::item_t              q_item,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pclp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pclp_pkg::*;

    localparam logic [HELD_W-1:0] PC_H   = HELD_W'(PREFIX_CHARS);
    localparam logic [HELD_W-1:0] FULL_H = HELD_W'(LINE_SLOTS - 1);
    localparam logic [DCNT_W-1:0] DMAX   = DCNT_W'(MAX_DIGITS_PLUS_ONE - 1);

    logic [15:0]       prefix_reg;
    logic [HELD_W-1:0] held_reg, held_next;
    fault_t            fault_reg, fault_next;
    logic              cmd_hit_reg, cmd_hit_next;
    logic [ROW_W-1:0]  cmd_row_reg, cmd_row_next;
    logic [15:0]       value_reg, value_next;
    logic [DCNT_W-1:0] dcount_reg, dcount_next;

    logic              out_valid_reg, out_valid_next;
    outcome_t          out_outcome_reg;
    logic [ROW_W-1:0]  out_index_reg;
    logic [15:0]       out_arg_reg;

    logic              res_valid;
    outcome_t          res_outcome;
    logic [ROW_W-1:0]  res_index;
    logic [15:0]       res_arg;

    assign pop      = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_arg_reg, out_index_reg, out_outcome_reg};

    always_comb begin
        held_next    = held_reg;
        fault_next   = fault_reg;
        cmd_hit_next = cmd_hit_reg;
        cmd_row_next = cmd_row_reg;
        value_next   = value_reg;
        dcount_next  = dcount_reg;
        res_valid    = 1'b0;
        res_outcome  = OUT_COMMAND;
        res_index    = '0;
        res_arg      = '0;
        if (pop) begin
            if (q_item.kind == KIND_NEWLINE) begin
                held_next    = '0;
                fault_next   = FAULT_NONE;
                cmd_hit_next = 1'b0;
                cmd_row_next = '0;
                value_next   = '0;
                dcount_next  = '0;
                if (held_reg > PC_H) begin
                    res_valid = 1'b1;
                    case (fault_reg)
                        FAULT_PREFIX:   res_outcome = OUT_PREFIX;
                        FAULT_NONDIGIT: res_outcome = OUT_NONDIGIT;
                        FAULT_TOOLONG:  res_outcome = OUT_TOOLONG;
                        default: begin
                            if (cmd_hit_reg) begin
                                res_outcome = OUT_COMMAND;
                                res_index   = cmd_row_reg;
                                res_arg     = value_reg;
                            end else begin
                                res_outcome = OUT_UNKNOWN;
                            end
                        end
                    endcase
                end
            end else if (held_reg < FULL_H) begin
                held_next = held_reg + 1'b1;
                if (held_reg < PC_H) begin
                    if ((fault_reg == FAULT_NONE)
                        && (q_item.data != prefix_char(prefix_reg, held_reg))) begin
                        fault_next = FAULT_PREFIX;
                    end
                end else if (held_reg == PC_H) begin
                    cmd_hit_next = q_item.cmd_hit;
                    cmd_row_next = q_item.cmd_row;
                end else if (fault_reg == FAULT_NONE) begin
                    if (!q_item.is_digit) begin
                        fault_next = FAULT_NONDIGIT;
                    end else if (dcount_reg < DMAX) begin
                        value_next  = {value_reg[12:0], 3'b000} + {value_reg[14:0], 1'b0}
                                      + 16'(q_item.digit);
                        dcount_next = dcount_reg + 1'b1;
                    end else begin
                        fault_next = FAULT_TOOLONG;
                    end
                end
            end else begin
                res_valid   = 1'b1;
                res_outcome = OUT_OVERFLOW;
            end
        end
        out_valid_next = (out_valid_reg && !m_tready) || res_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg    <= PREFIX_RESET;
            held_reg      <= '0;
            fault_reg     <= FAULT_NONE;
            cmd_hit_reg   <= 1'b0;
            cmd_row_reg   <= '0;
            value_reg     <= '0;
            dcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                prefix_reg <= cfg_wdata;
            end
            held_reg      <= held_next;
            fault_reg     <= fault_next;
            cmd_hit_reg   <= cmd_hit_next;
            cmd_row_reg   <= cmd_row_next;
            value_reg     <= value_next;
            dcount_reg    <= dcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_outcome_reg <= res_outcome;
            out_index_reg   <= res_index;
            out_arg_reg     <= res_arg;
        end
    end

endmodule

/* rtl/prefixed_command_line_parser_unit.sv */
// Top level of the prefixed command line parser.
// Usage:
// Received bytes enter on the s_ stream channel, one byte per transaction in
// s_tdata. Carriage returns are dropped, a newline closes the line. Each line
// result leaves on the m_ stream channel: outcome, command index and argument.
// The prefix register is written through cfg_we and cfg_wdata; write it only
// while the block is idle, the block itself does not enforce this.
// A byte accepted on s_ is written into the two-entry queue, popped by the line
// engine when the output register is free or being read, and its result is
// registered in the output register that drives m_tvalid.
// Throughput is one byte per cycle while the receiver does not stall; the line
// engine updates its counters and the decimal accumulator (a shift-and-add by ten) for each byte.
// Reset clears the line state and the queue and loads the prefix "$$".
// When the receiver stalls, the result stays in the output register, the line
// engine stops popping, and s_tready falls once the queue holds two bytes.
module prefixed_command_line_parser_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [15:0]                      cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pclp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pclp_pkg::OUT_TDATA_W-1:0] m_tdata    // [2:0] outcome, [6:3] command_index,
                                                        // [22:7] argument, [23] zero
);
    import pclp_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_valid;
    item_t q_item;

    pclp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    pclp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    pclp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* rtl/pclp_checker.sv */
// Port-level assertion checker of the command line parser and its bind statement.
`include "prefixed_command_line_parser_unit_macros.svh"

module pclp_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [pclp_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pclp_pkg::*;

    `PCLP_ASSERT_NEXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Stalled result transaction changed.")
    `PCLP_ASSERT_NOW(a_outcome_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= OUT_OVERFLOW, "Outcome code out of range.")
    `PCLP_ASSERT_NOW(a_fault_clean, aclk, aresetn, m_tvalid && (m_tdata[2:0] != OUT_COMMAND), (m_tdata[6:3] == '0) && (m_tdata[22:7] == '0), "Fault result carries index or argument.")
    `PCLP_ASSERT_NOW(a_index_range, aclk, aresetn, m_tvalid && (m_tdata[2:0] == OUT_COMMAND), m_tdata[6:3] < ROW_W'(CMD_ROWS), "Command index out of range.")

endmodule

bind prefixed_command_line_parser_unit pclp_checker u_pclp_checker (.*);
